### hw/rtl/scc_pkg.sv
// scc_pkg: shared types and constants of the system control coprocessor
// action codes, register numbers, read and write masks, vectors
// no dependencies
package scc_pkg;

  typedef enum logic [2:0] {
    FUNC_READ      = 3'd0,
    FUNC_MASKED_WR = 3'd1,
    FUNC_OVERRIDE  = 3'd2,
    FUNC_RFE       = 3'd3,
    FUNC_CACHE_MISS = 3'd4,
    FUNC_QUERY     = 3'd5,
    FUNC_RESET_EXC = 3'd6,
    FUNC_SET_COND  = 3'd7
  } func_t;

  localparam logic [4:0] REG_RANDOM   = 5'd1;
  localparam logic [4:0] REG_BADVADDR = 5'd8;
  localparam logic [4:0] REG_STATUS   = 5'd12;
  localparam logic [4:0] REG_CAUSE    = 5'd13;
  localparam logic [4:0] REG_EPC      = 5'd14;
  localparam logic [4:0] REG_PRID     = 5'd15;

  localparam logic [31:0] STATUS_READ_MASK  = 32'hF27F_FF3F;
  localparam logic [31:0] CAUSE_READ_MASK   = 32'hB000_FF7C;
  localparam logic [31:0] STATUS_WR_MASK    = 32'hF24B_FF3F;
  localparam logic [31:0] STATUS_KEEP_MASK  = 32'h0DB4_00C0;
  localparam logic [31:0] CAUSE_WR_MASK     = 32'h0000_0300;
  localparam logic [31:0] RESET_EXC_CLEAR   = 32'h0062_0003;
  localparam logic [31:0] RANDOM_RESET      = 32'h0000_3F00;
  localparam logic [31:0] PRID_VALUE        = 32'h0000_0002;
  localparam logic [31:0] VECTOR_BOOT       = 32'hBFC0_0180;
  localparam logic [31:0] VECTOR_NORMAL     = 32'h8000_0080;

  localparam int unsigned BIT_KUC  = 1;
  localparam int unsigned BIT_ISC  = 16;
  localparam int unsigned BIT_CM   = 19;
  localparam int unsigned BIT_BEV  = 22;
  localparam int unsigned BIT_RE   = 25;
  localparam int unsigned BIT_CU0  = 28;

endpackage

### hw/rtl/system_control_coprocessor_unit.sv
// system_control_coprocessor_unit: coprocessor 0 without a tlb, one request per action
// depends on scc_pkg
//
// A request is taken into an input register and, when the result register can take it,
// performs its register action and moves into the result register. The result is presented
// from the result register, and a new request can be accepted every cycle while the output
// is not stalled. The rate is set by the single pass through the status update logic
// between those two registers. Only registers that can be read back (random, badvaddr,
// status, cause, epc) are kept; writes to any other register number have no visible
// effect, and prid always reads 2. Mode outputs reflect the status after the request's
// own action.
module system_control_coprocessor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [31:0] address,
  input  logic [1:0]  cop_num,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [31:0] physical_address,
  output logic        cacheable,
  output logic        address_allowed,
  output logic        kernel_mode,
  output logic        opposite_byte_order,
  output logic        cache_isolated,
  output logic        cop_usable,
  output logic [31:0] exception_vector,
  output logic        condition_out
);

  logic        s1_valid;
  logic [2:0]  s1_func;
  logic [4:0]  s1_index;
  logic [31:0] s1_value;
  logic [31:0] s1_addr;
  logic [1:0]  s1_cop;

  logic [31:0] random, badvaddr, status, cause, epc;
  logic        cond;
  logic [31:0] random_next, badvaddr_next, status_next, cause_next, epc_next;
  logic        cond_next;

  logic        out_ready;
  logic        advance;
  logic [31:0] rd;
  logic [31:0] status_rd;
  logic [31:0] rfe_val;
  logic [31:0] phys;
  logic        is_wr;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_func  <= func;
      s1_index <= reg_index;
      s1_value <= write_value;
      s1_addr  <= address;
      s1_cop   <= cop_num;
    end
  end

  assign status_rd = status & scc_pkg::STATUS_READ_MASK;
  assign rfe_val   = {status_rd[31:4], status_rd[5:2]};
  assign is_wr     = (scc_pkg::func_t'(s1_func) == scc_pkg::FUNC_MASKED_WR) ||
                     (scc_pkg::func_t'(s1_func) == scc_pkg::FUNC_OVERRIDE);

  always_comb begin
    rd            = '0;
    random_next   = random;
    badvaddr_next = badvaddr;
    status_next   = status;
    cause_next    = cause;
    epc_next      = epc;
    cond_next     = cond;
    case (scc_pkg::func_t'(s1_func))
      scc_pkg::FUNC_READ: begin
        case (s1_index)
          scc_pkg::REG_STATUS:   rd = status_rd;
          scc_pkg::REG_CAUSE:    rd = cause & scc_pkg::CAUSE_READ_MASK;
          scc_pkg::REG_EPC:      rd = epc;
          scc_pkg::REG_BADVADDR: rd = badvaddr;
          scc_pkg::REG_RANDOM:   rd = random;
          scc_pkg::REG_PRID:     rd = scc_pkg::PRID_VALUE;
          default:               rd = '0;
        endcase
      end
      scc_pkg::FUNC_MASKED_WR, scc_pkg::FUNC_OVERRIDE: begin
        case (s1_index)
          scc_pkg::REG_STATUS: begin
            if (scc_pkg::func_t'(s1_func) == scc_pkg::FUNC_MASKED_WR) begin
              status_next = (s1_value & scc_pkg::STATUS_WR_MASK) |
                            (status & scc_pkg::STATUS_KEEP_MASK);
            end else begin
              status_next = s1_value;
            end
          end
          scc_pkg::REG_CAUSE: begin
            if (scc_pkg::func_t'(s1_func) == scc_pkg::FUNC_MASKED_WR) begin
              cause_next = (cause & ~scc_pkg::CAUSE_WR_MASK) |
                           (s1_value & scc_pkg::CAUSE_WR_MASK);
            end else begin
              cause_next = s1_value;
            end
          end
          scc_pkg::REG_EPC:      epc_next = s1_value;
          scc_pkg::REG_BADVADDR: badvaddr_next = s1_value;
          scc_pkg::REG_RANDOM:   random_next = s1_value;
          default: ;
        endcase
      end
      scc_pkg::FUNC_RFE: begin
        status_next = (rfe_val & scc_pkg::STATUS_WR_MASK) |
                      (status & scc_pkg::STATUS_KEEP_MASK);
      end
      scc_pkg::FUNC_CACHE_MISS: begin
        status_next[scc_pkg::BIT_CM] = s1_value[0];
      end
      scc_pkg::FUNC_QUERY: ;
      scc_pkg::FUNC_RESET_EXC: begin
        random_next = scc_pkg::RANDOM_RESET;
        status_next = status & ~scc_pkg::RESET_EXC_CLEAR;
        cond_next   = 1'b0;
      end
      scc_pkg::FUNC_SET_COND: cond_next = s1_value[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      random   <= scc_pkg::RANDOM_RESET;
      badvaddr <= '0;
      status   <= '0;
      cause    <= '0;
      epc      <= '0;
      cond     <= 1'b0;
    end else if (advance) begin
      random   <= random_next;
      badvaddr <= badvaddr_next;
      status   <= status_next;
      cause    <= cause_next;
      epc      <= epc_next;
      cond     <= cond_next;
    end
  end

  // kseg0 and kseg1 both drop the top three address bits
  assign phys = (s1_addr[31:30] == 2'b10) ? {3'b000, s1_addr[28:0]} : s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      read_data           <= rd;
      physical_address    <= phys;
      cacheable           <= !(s1_addr[31] && (s1_addr[30] || s1_addr[29]));
      address_allowed     <= !(s1_addr[31] && status_next[scc_pkg::BIT_KUC]);
      kernel_mode         <= !status_next[scc_pkg::BIT_KUC];
      opposite_byte_order <= status_next[scc_pkg::BIT_RE];
      cache_isolated      <= status_next[scc_pkg::BIT_ISC];
      cop_usable          <= status_next[scc_pkg::BIT_CU0 + 32'(s1_cop)];
      exception_vector    <= status_next[scc_pkg::BIT_BEV] ? scc_pkg::VECTOR_BOOT
                                                           : scc_pkg::VECTOR_NORMAL;
      condition_out       <= cond_next;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_reset_exc: assert property (@(posedge clk) disable iff (rst)
    advance && (scc_pkg::func_t'(s1_func) == scc_pkg::FUNC_RESET_EXC)
    |=> (random == scc_pkg::RANDOM_RESET) && !cond && !condition_out)
    else $error("reset exception did not restore random or condition");

  a_kernel_allowed: assert property (@(posedge clk) disable iff (rst)
    out_valid && kernel_mode |-> address_allowed)
    else $error("kernel mode access refused");

  a_prid_read: assert property (@(posedge clk) disable iff (rst)
    advance && (scc_pkg::func_t'(s1_func) == scc_pkg::FUNC_READ) &&
    (s1_index == scc_pkg::REG_PRID) |=> read_data == scc_pkg::PRID_VALUE)
    else $error("prid read wrong");

  a_no_write_no_change: assert property (@(posedge clk) disable iff (rst)
    advance && !is_wr && (scc_pkg::func_t'(s1_func) != scc_pkg::FUNC_RESET_EXC)
    |=> $stable(random) && $stable(cause) && $stable(epc))
    else $error("register changed without a write");

endmodule

### tb/tb_system_control_coprocessor_unit.sv
// tb_system_control_coprocessor_unit: self-checking bench for the system control coprocessor
// a shadow register file predicts every response; directed then random requests with idling
// depends on scc_pkg and system_control_coprocessor_unit
module tb_system_control_coprocessor_unit;
  import scc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RANDOM_PER_PHASE = 175;
  localparam logic [4:0] REG_UNLISTED = 5'd0;
  localparam logic [31:0] EXC_CLEAR_BITS = 32'h0062_0003;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] physical_address;
    logic        cacheable;
    logic        address_allowed;
    logic        kernel_mode;
    logic        opposite_byte_order;
    logic        cache_isolated;
    logic        cop_usable;
    logic [31:0] exception_vector;
    logic        condition_out;
  } view_t;

  class cop0_shadow;
    logic [31:0] regs [32];
    logic        cond;
    view_t       due_views [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_RANDOM] = RANDOM_RESET;
      cond = 1'b0;
      errors = 0;
    endfunction

    function logic [31:0] reg_view(logic [4:0] idx);
      case (idx)
        REG_STATUS: return regs[idx] & STATUS_READ_MASK;
        REG_CAUSE: return regs[idx] & CAUSE_READ_MASK;
        REG_RANDOM, REG_BADVADDR, REG_EPC: return regs[idx];
        REG_PRID: return PRID_VALUE;
        default: return '0;
      endcase
    endfunction

    function void masked_store(logic [4:0] idx, logic [31:0] val);
      if (idx == REG_STATUS) begin
        regs[idx] = (val & STATUS_WR_MASK) | (regs[idx] & STATUS_KEEP_MASK);
      end else if (idx == REG_CAUSE) begin
        regs[idx] = (regs[idx] & ~CAUSE_WR_MASK) | (val & CAUSE_WR_MASK);
      end else begin
        regs[idx] = val;
      end
    endfunction

    function void note_request(func_t f, logic [4:0] idx, logic [31:0] val,
                               logic [31:0] addr, logic [1:0] cop);
      view_t v;
      logic [31:0] t;
      logic [31:0] st;
      v = '0;
      case (f)
        FUNC_READ: v.read_data = reg_view(idx);
        FUNC_MASKED_WR: masked_store(idx, val);
        FUNC_OVERRIDE: regs[idx] = val;
        FUNC_RFE: begin
          t = reg_view(REG_STATUS);
          t = {t[31:4], t[5:2]};
          masked_store(REG_STATUS, t);
        end
        FUNC_CACHE_MISS: regs[REG_STATUS][BIT_CM] = val[0];
        FUNC_QUERY: ;
        FUNC_RESET_EXC: begin
          regs[REG_RANDOM] = RANDOM_RESET;
          regs[REG_STATUS] = regs[REG_STATUS] & ~EXC_CLEAR_BITS;
          cond = 1'b0;
        end
        default: cond = val[0];
      endcase
      st = regs[REG_STATUS];
      if (addr >= 32'h8000_0000 && addr < 32'hA000_0000) begin
        v.physical_address = addr - 32'h8000_0000;
      end else if (addr >= 32'hA000_0000 && addr < 32'hC000_0000) begin
        v.physical_address = addr - 32'hA000_0000;
      end else begin
        v.physical_address = addr;
      end
      v.cacheable = addr < 32'hA000_0000;
      v.address_allowed = !(addr[31] && st[BIT_KUC]);
      v.kernel_mode = !st[BIT_KUC];
      v.opposite_byte_order = st[BIT_RE];
      v.cache_isolated = st[BIT_ISC];
      v.cop_usable = st[BIT_CU0 + cop];
      v.exception_vector = st[BIT_BEV] ? VECTOR_BOOT : VECTOR_NORMAL;
      v.condition_out = cond;
      due_views.push_back(v);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_view(view_t got);
      view_t want;
      if (due_views.size() == 0) begin
        errors++;
        if (errors <= 10) $display("response with no request outstanding");
        return;
      end
      want = due_views.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("physical_address", want.physical_address, got.physical_address);
      compare_field("cacheable", want.cacheable, got.cacheable);
      compare_field("address_allowed", want.address_allowed, got.address_allowed);
      compare_field("kernel_mode", want.kernel_mode, got.kernel_mode);
      compare_field("opposite_byte_order", want.opposite_byte_order,
                    got.opposite_byte_order);
      compare_field("cache_isolated", want.cache_isolated, got.cache_isolated);
      compare_field("cop_usable", want.cop_usable, got.cop_usable);
      compare_field("exception_vector", want.exception_vector, got.exception_vector);
      compare_field("condition_out", want.condition_out, got.condition_out);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  func_t       func;
  logic [4:0]  reg_index;
  logic [31:0] write_value;
  logic [31:0] address;
  logic [1:0]  cop_num;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic [31:0] physical_address;
  logic        cacheable;
  logic        address_allowed;
  logic        kernel_mode;
  logic        opposite_byte_order;
  logic        cache_isolated;
  logic        cop_usable;
  logic [31:0] exception_vector;
  logic        condition_out;
  view_t       seen_view;

  cop0_shadow shadow = new();
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned cycle_count;

  system_control_coprocessor_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .reg_index(reg_index),
    .write_value(write_value),
    .address(address),
    .cop_num(cop_num),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .physical_address(physical_address),
    .cacheable(cacheable),
    .address_allowed(address_allowed),
    .kernel_mode(kernel_mode),
    .opposite_byte_order(opposite_byte_order),
    .cache_isolated(cache_isolated),
    .cop_usable(cop_usable),
    .exception_vector(exception_vector),
    .condition_out(condition_out)
  );

  assign seen_view = {read_data, physical_address, cacheable, address_allowed, kernel_mode,
                      opposite_byte_order, cache_isolated, cop_usable, exception_vector,
                      condition_out};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        shadow.note_request(func, reg_index, write_value, address, cop_num);
      if (out_valid && !out_stall)
        shadow.check_view(seen_view);
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done = holds_done + 1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
        @(posedge clk);
      end
    end
  end

  task automatic send(func_t f, logic [4:0] idx, logic [31:0] val, logic [31:0] addr,
                      logic [1:0] cop);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    reg_index <= idx;
    write_value <= val;
    address <= addr;
    cop_num <= cop;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    func_t f;
    logic [4:0] idx;
    logic [31:0] val;
    logic [31:0] addr;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) f = FUNC_READ;
    else if (pick < 50) f = FUNC_MASKED_WR;
    else if (pick < 62) f = FUNC_OVERRIDE;
    else if (pick < 70) f = FUNC_RFE;
    else if (pick < 77) f = FUNC_CACHE_MISS;
    else if (pick < 85) f = FUNC_QUERY;
    else if (pick < 90) f = FUNC_RESET_EXC;
    else f = FUNC_SET_COND;
    case ($urandom_range(9))
      0: idx = REG_RANDOM;
      1: idx = REG_BADVADDR;
      2, 3: idx = REG_STATUS;
      4: idx = REG_CAUSE;
      5: idx = REG_EPC;
      6: idx = REG_PRID;
      default: idx = $urandom_range(31);
    endcase
    case ($urandom_range(9))
      0: val = '0;
      1: val = '1;
      default: val = $urandom;
    endcase
    case ($urandom_range(3))
      0: addr = {3'($urandom_range(7)), 29'h0};
      1: addr = {3'($urandom_range(7)), 29'h1FFF_FFFF};
      default: addr = $urandom;
    endcase
    send(f, idx, val, addr, 2'($urandom_range(3)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_QUERY;
    reg_index = '0;
    write_value = '0;
    address = '0;
    cop_num = '0;
    cycle_count = 0;
    hold_requests = 0;
    send_idle = 14;
    recv_idle = 79;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reads after reset across address regions and coprocessor numbers
    send(FUNC_READ, REG_RANDOM, 32'h0, 32'h0000_0000, 2'd0);
    send(FUNC_READ, REG_STATUS, 32'h0, 32'h7FFF_FFFF, 2'd1);
    send(FUNC_READ, REG_CAUSE, 32'h0, 32'h8000_0000, 2'd2);
    send(FUNC_READ, REG_PRID, 32'h0, 32'h9FFF_FFFF, 2'd3);
    send(FUNC_READ, REG_BADVADDR, 32'h0, 32'hA000_0000, 2'd0);
    send(FUNC_READ, REG_EPC, 32'h0, 32'hBFFF_FFFF, 2'd1);
    send(FUNC_READ, REG_UNLISTED, 32'h0, 32'hC000_0000, 2'd2);
    // user mode with all status bits set
    send(FUNC_OVERRIDE, REG_STATUS, 32'hFFFF_FFFF, 32'h8000_0000, 2'd3);
    send(FUNC_READ, REG_STATUS, 32'h0, 32'h7FFF_FFFF, 2'd0);
    send(FUNC_MASKED_WR, REG_STATUS, 32'h0000_0000, 32'hA000_0000, 2'd1);
    send(FUNC_READ, REG_STATUS, 32'h0, 32'h0, 2'd2);
    send(FUNC_MASKED_WR, REG_CAUSE, 32'hFFFF_FFFF, 32'h0, 2'd3);
    send(FUNC_READ, REG_CAUSE, 32'h0, 32'h0, 2'd0);
    send(FUNC_MASKED_WR, REG_PRID, 32'hFFFF_FFFF, 32'h0, 2'd0);
    send(FUNC_READ, REG_PRID, 32'h0, 32'h0, 2'd0);
    // mode stack pop
    send(FUNC_OVERRIDE, REG_STATUS, 32'h0000_003C, 32'hFFFF_FFFF, 2'd0);
    send(FUNC_RFE, REG_UNLISTED, 32'h0, 32'hFFFF_FFFF, 2'd0);
    send(FUNC_READ, REG_STATUS, 32'h0, 32'h8000_0000, 2'd0);
    send(FUNC_CACHE_MISS, REG_UNLISTED, 32'h0000_0001, 32'h0, 2'd0);
    send(FUNC_CACHE_MISS, REG_UNLISTED, 32'hFFFF_FFFE, 32'h0, 2'd0);
    // reset exception from all ones with the condition line raised
    send(FUNC_OVERRIDE, REG_STATUS, 32'hFFFF_FFFF, 32'h0, 2'd0);
    send(FUNC_SET_COND, REG_UNLISTED, 32'h0000_0001, 32'h0, 2'd0);
    send(FUNC_RESET_EXC, REG_UNLISTED, 32'h0, 32'h0, 2'd0);
    send(FUNC_READ, REG_STATUS, 32'h0, 32'h0, 2'd3);
    send(FUNC_QUERY, REG_UNLISTED, 32'h0, 32'hFFFF_FFFF, 2'd2);

    repeat (RANDOM_PER_PHASE) send_random();
    send_idle = 79;
    recv_idle = 14;
    repeat (RANDOM_PER_PHASE) send_random();
    send_idle = 0;
    recv_idle = 0;
    hold_requests = hold_requests + 1;
    repeat (RANDOM_PER_PHASE) send_random();
    in_valid <= 1'b0;

    while (shadow.due_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.errors == 0 && shadow.due_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/scc_pkg.sv
hw/rtl/system_control_coprocessor_unit.sv
tb/tb_system_control_coprocessor_unit.sv
